// File: hw/rtl/bresenham_line_pixel_stepper_top_defines.svh
// assertion macros used by the line stepper core
`ifndef BRESENHAM_LINE_PIXEL_STEPPER_TOP_DEFINES_SVH
`define BRESENHAM_LINE_PIXEL_STEPPER_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define BLS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define BLS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/bls_pkg.sv
// types and constants for the line pixel stepper
`default_nettype none

package bls_pkg;

  localparam int unsigned COL_W   = 9;
  localparam int unsigned ROW_W   = 8;
  localparam int unsigned POS_W   = 9;
  localparam int unsigned ERR_W   = 11;
  localparam int unsigned COLOR_W = 16;
  localparam int unsigned ADDR_W  = 32;

  localparam logic [ADDR_W-1:0] FRAME_BASE_RESET = 32'hC800_0000;

  // action codes
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  // one input beat
  typedef struct packed {
    logic               action;
    logic [COL_W-1:0]   x_start;
    logic [COL_W-1:0]   x_end;
    logic [ROW_W-1:0]   y_start;
    logic [ROW_W-1:0]   y_end;
    logic [COLOR_W-1:0] stroke_color;
  } item_t;

  // one output beat
  typedef struct packed {
    logic [ADDR_W-1:0]  address;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pixel_t;

  // core to output register
  typedef struct packed {
    logic   valid;
    pixel_t pixel;
  } emit_t;

endpackage

`default_nettype wire

// File: hw/rtl/bls_in_stage.sv
// input register holding one accepted beat until the core takes it
`default_nettype none

module bls_in_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_stall,
  input  wire bls_pkg::item_t item_in,
  input  wire logic           consume,
  output logic                held_valid,
  output bls_pkg::item_t      held_item
);

  logic accept;
  logic held_valid_next;

  // stall only while a beat sits here and the core cannot take it
  assign item_stall = held_valid && !consume;
  assign accept     = item_valid && !item_stall;

  always_comb begin
    held_valid_next = held_valid;
    if (accept) begin
      held_valid_next = 1'b1;
    end else if (consume) begin
      held_valid_next = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= held_valid_next;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      held_item <= item_in;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bls_core.sv
// line state, load setup and one bresenham step per consumed step beat while a line is busy
`default_nettype none
`include "bresenham_line_pixel_stepper_top_defines.svh"

module bls_core #(
  parameter int unsigned ROW_SHIFT = 10
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        consume,
  input  wire bls_pkg::item_t              item,
  input  wire logic [bls_pkg::ADDR_W-1:0]  frame_base,
  output bls_pkg::emit_t                   emit
);

  localparam int unsigned PW = bls_pkg::POS_W;
  localparam int unsigned EW = bls_pkg::ERR_W;

  // line state
  logic                        busy, busy_next;
  logic                        steep, steep_next;
  logic [PW-1:0]               major_pos, major_pos_next;
  logic [PW-1:0]               major_end, major_end_next;
  logic [PW-1:0]               minor_pos, minor_pos_next;
  logic                        minor_down, minor_down_next;
  logic [PW-1:0]               major_delta, major_delta_next;
  logic [PW-1:0]               minor_delta, minor_delta_next;
  logic signed [EW-1:0]        error_term, error_term_next;
  logic [bls_pkg::COLOR_W-1:0] held_color, held_color_next;

  // load setup
  logic [PW-1:0] xs, xe, ys, ye, dx, dy;
  logic          ld_steep;
  logic [PW-1:0] a0, a1, b0, b1;

  // step
  logic [PW-1:0]                x_cur, y_cur;
  logic [bls_pkg::ADDR_W-1:0]   row_off, col_off;
  logic                         at_end;
  logic signed [EW-1:0]         err_sum;
  logic                         is_load, is_step;

  assign is_load = consume && (item.action == bls_pkg::ACT_LOAD);
  assign is_step = consume && (item.action == bls_pkg::ACT_STEP);

  // endpoint ordering along the major axis
  always_comb begin
    xs = item.x_start;
    xe = item.x_end;
    ys = {1'b0, item.y_start};
    ye = {1'b0, item.y_end};
    dx = (xs > xe) ? xs - xe : xe - xs;
    dy = (ys > ye) ? ys - ye : ye - ys;
    ld_steep = dy > dx;
    if (ld_steep) begin
      a0 = ys; a1 = ye; b0 = xs; b1 = xe;
    end else begin
      a0 = xs; a1 = xe; b0 = ys; b1 = ye;
    end
    if (a0 > a1) begin
      {a0, a1} = {a1, a0};
      {b0, b1} = {b1, b0};
    end
  end

  // pixel address and end test
  always_comb begin
    x_cur   = steep ? minor_pos : major_pos;
    y_cur   = steep ? major_pos : minor_pos;
    row_off = {{(bls_pkg::ADDR_W-PW){1'b0}}, y_cur} << ROW_SHIFT;
    col_off = {{(bls_pkg::ADDR_W-PW-1){1'b0}}, x_cur, 1'b0};
    at_end  = major_pos == major_end;
    err_sum = error_term + $signed({{(EW-PW){1'b0}}, minor_delta});
  end

  // result beat
  always_comb begin
    emit.valid         = is_step && busy;
    emit.pixel.address = frame_base + row_off + col_off;
    emit.pixel.color   = held_color;
    emit.pixel.last    = at_end;
  end

  // next state
  always_comb begin
    busy_next        = busy;
    steep_next       = steep;
    major_pos_next   = major_pos;
    major_end_next   = major_end;
    minor_pos_next   = minor_pos;
    minor_down_next  = minor_down;
    major_delta_next = major_delta;
    minor_delta_next = minor_delta;
    error_term_next  = error_term;
    held_color_next  = held_color;
    if (is_load) begin
      busy_next        = 1'b1;
      steep_next       = ld_steep;
      major_pos_next   = a0;
      major_end_next   = a1;
      minor_pos_next   = b0;
      minor_down_next  = b0 > b1;
      major_delta_next = a1 - a0;
      minor_delta_next = (b0 > b1) ? b0 - b1 : b1 - b0;
      error_term_next  = -$signed({{(EW-PW+1){1'b0}}, major_delta_next[PW-1:1]});
      held_color_next  = item.stroke_color;
    end else if (is_step && busy) begin
      if (at_end) begin
        busy_next = 1'b0;
      end else begin
        major_pos_next  = major_pos + 1'b1;
        error_term_next = err_sum;
        if (err_sum > 0) begin
          minor_pos_next  = minor_down ? minor_pos - 1'b1 : minor_pos + 1'b1;
          error_term_next = err_sum - $signed({{(EW-PW){1'b0}}, major_delta});
        end
      end
    end
  end

  // busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= busy_next;
    end
  end

  // line registers, only meaningful while busy
  always_ff @(posedge clk) begin
    steep       <= steep_next;
    major_pos   <= major_pos_next;
    major_end   <= major_end_next;
    minor_pos   <= minor_pos_next;
    minor_down  <= minor_down_next;
    major_delta <= major_delta_next;
    minor_delta <= minor_delta_next;
    error_term  <= error_term_next;
    held_color  <= held_color_next;
  end

  `BLS_ASSERT_NXT(a_load_busy, clk, rst, is_load, busy && (major_pos <= major_end),
    "load did not start a line")
  `BLS_ASSERT_IMP(a_major_bound, clk, rst, busy, major_pos <= major_end,
    "major coordinate passed the endpoint")
  `BLS_ASSERT_NXT(a_last_idle, clk, rst, emit.valid && emit.pixel.last, !busy,
    "line still busy after last pixel")
  `BLS_ASSERT_NXT(a_idle_step, clk, rst, is_step && !busy, !busy,
    "step while idle started a line")

endmodule

`default_nettype wire

// File: hw/rtl/bls_out_stage.sv
// output register for pixel beats
`default_nettype none

module bls_out_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire bls_pkg::emit_t  emit,
  output logic                 out_free,
  output logic                 pixel_valid,
  input  wire logic            pixel_stall,
  output bls_pkg::pixel_t      pixel
);

  // register may load when empty or being drained this cycle
  assign out_free = !pixel_valid || !pixel_stall;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (out_free) begin
      pixel_valid <= emit.valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (out_free && emit.valid) begin
      pixel <= emit.pixel;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bresenham_line_pixel_stepper_top.sv
// a step beat waits in the input register; its pixel is registered in the output register
// throughput: one beat per cycle, loads and steps alike, while the output drains
// the figure is set by the combinational error-term add, compare and subtract
// reset: rst synchronous; clears busy and both valid flags, frame_base to 0xC8000000
// reset needs no clearing pass
`default_nettype none

module bresenham_line_pixel_stepper_top #(
  parameter int unsigned ROW_SHIFT = 10
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [bls_pkg::ADDR_W-1:0]     cfg_data,
  input  wire logic                           item_valid,
  output logic                                item_stall,
  input  wire logic                           action,
  input  wire logic [bls_pkg::COL_W-1:0]      x_start,
  input  wire logic [bls_pkg::COL_W-1:0]      x_end,
  input  wire logic [bls_pkg::ROW_W-1:0]      y_start,
  input  wire logic [bls_pkg::ROW_W-1:0]      y_end,
  input  wire logic [bls_pkg::COLOR_W-1:0]    stroke_color,
  output logic                                pixel_valid,
  input  wire logic                           pixel_stall,
  output logic [bls_pkg::ADDR_W-1:0]          pixel_address,
  output logic [bls_pkg::COLOR_W-1:0]         pixel_color,
  output logic                                last_pixel
);

  logic [bls_pkg::ADDR_W-1:0] frame_base;
  bls_pkg::item_t             item_in;
  bls_pkg::item_t             held_item;
  logic                       held_valid;
  logic                       out_free;
  logic                       consume;
  bls_pkg::emit_t             emit;
  bls_pkg::pixel_t            pixel;

  // frame base register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base <= bls_pkg::FRAME_BASE_RESET;
    end else if (cfg_write) begin
      frame_base <= cfg_data;
    end
  end

  // pack input fields
  always_comb begin
    item_in.action       = action;
    item_in.x_start      = x_start;
    item_in.x_end        = x_end;
    item_in.y_start      = y_start;
    item_in.y_end        = y_end;
    item_in.stroke_color = stroke_color;
  end

  // held beat moves on when the output register can take its result
  assign consume = held_valid && out_free;

  bls_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item_in    (item_in),
    .consume    (consume),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  bls_core #(
    .ROW_SHIFT (ROW_SHIFT)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .consume    (consume),
    .item       (held_item),
    .frame_base (frame_base),
    .emit       (emit)
  );

  bls_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .emit        (emit),
    .out_free    (out_free),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel)
  );

  // unpack output fields
  assign pixel_address = pixel.address;
  assign pixel_color   = pixel.color;
  assign last_pixel    = pixel.last;

endmodule

`default_nettype wire

// File: dv/tb_bresenham_line_pixel_stepper_top.sv
// self-checking testbench for the bresenham line pixel stepper top level
`timescale 1ns / 1ps

module tb_bresenham_line_pixel_stepper_top;

  localparam int unsigned ROW_SHIFT = 10;

  // how a beat's result is judged
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_PIXEL,
    CHK_NONE
  } check_t;

  typedef struct {
    bls_pkg::item_t  beat;
    check_t          kind;
    bls_pkg::pixel_t pix;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [bls_pkg::ADDR_W-1:0] cfg_data;
  logic item_valid;
  logic item_stall;
  logic action;
  logic [bls_pkg::COL_W-1:0] x_start;
  logic [bls_pkg::COL_W-1:0] x_end;
  logic [bls_pkg::ROW_W-1:0] y_start;
  logic [bls_pkg::ROW_W-1:0] y_end;
  logic [bls_pkg::COLOR_W-1:0] stroke_color;
  logic pixel_valid;
  logic pixel_stall = 1'b0;
  logic [bls_pkg::ADDR_W-1:0] pixel_address;
  logic [bls_pkg::COLOR_W-1:0] pixel_color;
  logic last_pixel;

  // beat metadata travels with the offered beat
  check_t offer_kind;
  bls_pkg::pixel_t offer_pixel;

  // receiver pattern and long hold-off
  logic holdoff_go = 1'b0;
  logic hold_off = 1'b0;
  int unsigned stall_cycle = 0;
  int unsigned stall_mode = 0;

  // line tracker state
  logic [bls_pkg::ADDR_W-1:0] frame_base_q;
  logic ln_busy;
  logic ln_steep;
  logic [bls_pkg::POS_W-1:0] ln_major;
  logic [bls_pkg::POS_W-1:0] ln_major_end;
  logic [bls_pkg::POS_W-1:0] ln_minor;
  logic ln_minor_down;
  logic [bls_pkg::POS_W-1:0] ln_major_len;
  logic [bls_pkg::POS_W-1:0] ln_minor_len;
  logic signed [bls_pkg::ERR_W-1:0] ln_err;
  logic [bls_pkg::COLOR_W-1:0] ln_color;

  bls_pkg::pixel_t pending_pixels[$];
  dir_row_t directed_tbl[$];

  int mismatches = 0;
  int pixels_checked = 0;
  int line_ends = 0;
  int loads_seen = 0;
  int steep_lines = 0;
  int bases_used = 1;
  int burst_left = 1;

  bresenham_line_pixel_stepper_top #(
    .ROW_SHIFT(ROW_SHIFT)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .action       (action),
    .x_start      (x_start),
    .x_end        (x_end),
    .y_start      (y_start),
    .y_end        (y_end),
    .stroke_color (stroke_color),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel_address(pixel_address),
    .pixel_color  (pixel_color),
    .last_pixel   (last_pixel)
  );

  always #6 clk = ~clk;

  // advance the line tracker by one beat; returns 1 when a pixel comes out
  function automatic bit line_step(input bls_pkg::item_t b, output bls_pkg::pixel_t px);
    logic [bls_pkg::POS_W-1:0] a0, a1, b0, b1, t, dx, dy, xcol, yrow;
    logic signed [bls_pkg::ERR_W-1:0] e;
    px = '0;
    if (b.action == bls_pkg::ACT_LOAD) begin
      dx = (b.x_start > b.x_end) ? b.x_start - b.x_end : b.x_end - b.x_start;
      dy = (b.y_start > b.y_end) ? b.y_start - b.y_end : b.y_end - b.y_start;
      ln_steep = dy > dx;
      if (ln_steep) begin
        a0 = bls_pkg::POS_W'(b.y_start);
        a1 = bls_pkg::POS_W'(b.y_end);
        b0 = b.x_start;
        b1 = b.x_end;
      end else begin
        a0 = b.x_start;
        a1 = b.x_end;
        b0 = bls_pkg::POS_W'(b.y_start);
        b1 = bls_pkg::POS_W'(b.y_end);
      end
      // walk the major axis upward
      if (a0 > a1) begin
        t = a0; a0 = a1; a1 = t;
        t = b0; b0 = b1; b1 = t;
      end
      ln_major = a0;
      ln_major_end = a1;
      ln_minor = b0;
      ln_minor_down = b0 > b1;
      ln_major_len = a1 - a0;
      ln_minor_len = (b0 > b1) ? b0 - b1 : b1 - b0;
      ln_err = -$signed({2'b00, ln_major_len >> 1});
      ln_color = b.stroke_color;
      ln_busy = 1'b1;
      loads_seen++;
      if (ln_steep) steep_lines++;
      return 1'b0;
    end
    if (!ln_busy) return 1'b0;
    xcol = ln_steep ? ln_minor : ln_major;
    yrow = ln_steep ? ln_major : ln_minor;
    px.address = frame_base_q + (bls_pkg::ADDR_W'(yrow) << ROW_SHIFT)
                 + (bls_pkg::ADDR_W'(xcol) << 1);
    px.color = ln_color;
    px.last = ln_major == ln_major_end;
    if (px.last) begin
      ln_busy = 1'b0;
    end else begin
      // error term decides whether the minor axis moves
      ln_major = ln_major + 1'b1;
      e = ln_err + $signed({2'b00, ln_minor_len});
      if (e > 0) begin
        ln_minor = ln_minor_down ? ln_minor - 1'b1 : ln_minor + 1'b1;
        e = e - $signed({2'b00, ln_major_len});
      end
      ln_err = e;
    end
    return 1'b1;
  endfunction

  function automatic void note_mismatch(input string what, input bls_pkg::pixel_t want,
                                        input bls_pkg::pixel_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s) at %0t: expected addr %h color %h last %b",
               what, $realtime, want.address, want.color, want.last);
      $display("  got addr %h color %h last %b", got.address, got.color, got.last);
    end
  endfunction

  function automatic dir_row_t load_row(input int xs, input int xe, input int ys,
                                        input int ye, input int col);
    dir_row_t r;
    r.beat.action = bls_pkg::ACT_LOAD;
    r.beat.x_start = bls_pkg::COL_W'(xs);
    r.beat.x_end = bls_pkg::COL_W'(xe);
    r.beat.y_start = bls_pkg::ROW_W'(ys);
    r.beat.y_end = bls_pkg::ROW_W'(ye);
    r.beat.stroke_color = bls_pkg::COLOR_W'(col);
    r.kind = CHK_NONE;
    r.pix = '0;
    return r;
  endfunction

  function automatic dir_row_t step_row(input check_t k,
                                        input logic [bls_pkg::ADDR_W-1:0] a,
                                        input logic [bls_pkg::COLOR_W-1:0] c,
                                        input logic l);
    dir_row_t r;
    r.beat = '0;
    r.beat.action = bls_pkg::ACT_STEP;
    r.kind = k;
    r.pix.address = a;
    r.pix.color = c;
    r.pix.last = l;
    return r;
  endfunction

  function automatic bls_pkg::item_t rand_beat(input logic act);
    bls_pkg::item_t b;
    b.action = act;
    b.x_start = bls_pkg::COL_W'($urandom);
    b.x_end = bls_pkg::COL_W'($urandom);
    b.y_start = bls_pkg::ROW_W'($urandom);
    b.y_end = bls_pkg::ROW_W'($urandom);
    b.stroke_color = bls_pkg::COLOR_W'($urandom);
    return b;
  endfunction

  function automatic int clamp_to(input int v, input int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // offer one beat, hold it until accepted, then maybe pause between bursts
  task automatic send_beat(input bls_pkg::item_t b, input check_t k,
                           input bls_pkg::pixel_t p);
    int gap;
    item_valid <= 1'b1;
    action <= b.action;
    x_start <= b.x_start;
    x_end <= b.x_end;
    y_start <= b.y_start;
    y_end <= b.y_end;
    stroke_color <= b.stroke_color;
    offer_kind <= k;
    offer_pixel <= p;
    do @(posedge clk); while (!(item_valid && !item_stall));
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // wait until every predicted pixel has come out and the core has settled
  task automatic drain_pixels();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_frame_base(input logic [bls_pkg::ADDR_W-1:0] v);
    cfg_write <= 1'b1;
    cfg_data <= v;
    frame_base_q = v;
    bases_used++;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // mostly whole lines with random shape, some cut short, some stray steps
  task automatic run_random(input int budget);
    int done, xs, xe, ys, ye, d, n, pix, i, r;
    bls_pkg::item_t b;
    done = 0;
    while (done < budget) begin
      r = $urandom_range(0, 15);
      if (r == 0) begin
        send_beat(rand_beat(bls_pkg::ACT_STEP), CHK_MODEL, '0);
      end else begin
        xs = $urandom_range(0, 511);
        ys = $urandom_range(0, 255);
        d = $urandom_range(0, 40);
        case ($urandom_range(0, 24))
          0: begin
            xe = $urandom_range(0, 511);
            ye = $urandom_range(0, 255);
          end
          1, 2: begin
            xe = xs;
            ye = ys;
          end
          3, 4, 5: begin
            xe = clamp_to(xs + d - 20, 511);
            ye = ys;
          end
          6, 7, 8: begin
            xe = xs;
            ye = clamp_to(ys + d - 20, 255);
          end
          9, 10, 11: begin
            d = d / 2 + 1;
            xe = (xs + d <= 511) ? xs + d : xs - d;
            ye = (ys + d <= 255) ? ys + d : ys - d;
          end
          default: begin
            xe = clamp_to(xs + d - 20, 511);
            ye = clamp_to(ys + int'($urandom_range(0, 40)) - 20, 255);
          end
        endcase
        b = rand_beat(bls_pkg::ACT_LOAD);
        b.x_start = bls_pkg::COL_W'(xs);
        b.x_end = bls_pkg::COL_W'(xe);
        b.y_start = bls_pkg::ROW_W'(ys);
        b.y_end = bls_pkg::ROW_W'(ye);
        send_beat(b, CHK_MODEL, '0);
        done++;
        pix = ((xs > xe ? xs - xe : xe - xs) > (ys > ye ? ys - ye : ye - ys)) ?
              (xs > xe ? xs - xe : xe - xs) + 1 : (ys > ye ? ys - ye : ye - ys) + 1;
        n = (r == 1) ? $urandom_range(0, pix) : pix + $urandom_range(0, 2);
        for (i = 0; i < n; i++) begin
          send_beat(rand_beat(bls_pkg::ACT_STEP), CHK_MODEL, '0);
          if (i < pix) done++;
        end
      end
    end
  endtask

  // receiver stall pattern, mode picked anew whenever the low six bits of the cycle counter are zero
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1;
    if (stall_cycle[5:0] == 6'd0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: pixel_stall <= hold_off;
      1: pixel_stall <= hold_off || ($urandom_range(0, 99) < 30);
      2: pixel_stall <= hold_off || (stall_cycle % 3 == 0);
      default: pixel_stall <= hold_off || ($urandom_range(0, 99) < 70);
    endcase
  end

  // one long hold-off so the core backs up and stalls its input
  initial begin : receiver_holdoff
    int n;
    wait (holdoff_go);
    @(posedge clk);
    hold_off <= 1'b1;
    for (n = 0; n < 300; n++) @(posedge clk);
    hold_off <= 1'b0;
  end

  // predict on accepted input beats, check accepted output beats
  always @(posedge clk) begin : scoreboard
    bls_pkg::pixel_t want, got;
    bls_pkg::item_t b;
    bit made;
    got.address = pixel_address;
    got.color = pixel_color;
    got.last = last_pixel;
    if (!rst && pixel_valid && !pixel_stall) begin
      if (pending_pixels.size() == 0) begin
        note_mismatch("no pixel expected", '0, got);
      end else begin
        want = pending_pixels.pop_front();
        pixels_checked++;
        if (want.last) line_ends++;
        if (got.address !== want.address || got.color !== want.color ||
            got.last !== want.last) begin
          note_mismatch("pixel", want, got);
        end
      end
    end
    if (!rst && item_valid && !item_stall) begin
      b.action = action;
      b.x_start = x_start;
      b.x_end = x_end;
      b.y_start = y_start;
      b.y_end = y_end;
      b.stroke_color = stroke_color;
      made = line_step(b, want);
      if (offer_kind == CHK_PIXEL) pending_pixels.push_back(offer_pixel);
      else if (offer_kind == CHK_MODEL && made) pending_pixels.push_back(want);
    end
  end

  initial begin : stimulus
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = '0;
    item_valid = 1'b0;
    action = bls_pkg::ACT_STEP;
    x_start = '0;
    x_end = '0;
    y_start = '0;
    y_end = '0;
    stroke_color = '0;
    offer_kind = CHK_MODEL;
    offer_pixel = '0;
    frame_base_q = bls_pkg::FRAME_BASE_RESET;
    ln_busy = 1'b0;
    ln_steep = 1'b0;
    ln_major = '0;
    ln_major_end = '0;
    ln_minor = '0;
    ln_minor_down = 1'b0;
    ln_major_len = '0;
    ln_minor_len = '0;
    ln_err = '0;
    ln_color = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed lines at the reset frame base
    directed_tbl = {
      step_row(CHK_NONE, '0, '0, 1'b0),                     // step while idle
      load_row(0, 0, 0, 0, 'hFFFF),                         // single pixel at origin
      step_row(CHK_PIXEL, 32'hC800_0000, 16'hFFFF, 1'b1),
      step_row(CHK_NONE, '0, '0, 1'b0),                     // idle again after last
      load_row(511, 511, 255, 255, 'h0000),                 // far corner
      step_row(CHK_PIXEL, 32'hC803_FFFE, 16'h0000, 1'b1),
      load_row(0, 3, 0, 3, 'h1234),                         // equal extents, not steep
      step_row(CHK_MODEL, '0, '0, 1'b0),
      step_row(CHK_MODEL, '0, '0, 1'b0),
      step_row(CHK_MODEL, '0, '0, 1'b0),
      step_row(CHK_MODEL, '0, '0, 1'b0),
      load_row(2, 0, 10, 0, 'hA5A5),                        // steep, reversed endpoints
      step_row(CHK_MODEL, '0, '0, 1'b0),
      step_row(CHK_MODEL, '0, '0, 1'b0),
      step_row(CHK_MODEL, '0, '0, 1'b0),
      load_row(511, 0, 0, 255, 'h5A5A),                     // replaces a running line
      step_row(CHK_MODEL, '0, '0, 1'b0),
      step_row(CHK_MODEL, '0, '0, 1'b0),
      load_row(100, 105, 7, 7, 'h8001),                     // flat, replaces again
      step_row(CHK_MODEL, '0, '0, 1'b0),
      step_row(CHK_MODEL, '0, '0, 1'b0),
      step_row(CHK_MODEL, '0, '0, 1'b0),
      step_row(CHK_MODEL, '0, '0, 1'b0),
      step_row(CHK_MODEL, '0, '0, 1'b0),
      step_row(CHK_PIXEL, 32'hC800_1CD2, 16'h8001, 1'b1),
      step_row(CHK_NONE, '0, '0, 1'b0)
    };
    foreach (directed_tbl[i]) send_beat(directed_tbl[i].beat, directed_tbl[i].kind,
                                        directed_tbl[i].pix);

    // random lines, with the long receiver hold-off early on
    holdoff_go <= 1'b1;
    run_random(200);
    drain_pixels();

    // further frame bases: zero, all ones (any nonzero offset wraps), random, high
    set_frame_base('0);
    run_random(170);
    drain_pixels();
    set_frame_base('1);
    run_random(170);
    drain_pixels();
    set_frame_base(bls_pkg::ADDR_W'($urandom));
    run_random(170);
    drain_pixels();
    set_frame_base(32'hFFFF_0000);
    run_random(140);
    drain_pixels();

    $display("checked %0d pixels and %0d line ends over %0d loads (%0d steep)",
             pixels_checked, line_ends, loads_seen, steep_lines);
    $display("used %0d frame base settings, %0d mismatches", bases_used, mismatches);
    if (pending_pixels.size() != 0) begin
      $display("%0d expected pixels never came out", pending_pixels.size());
    end
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
